FILE: hw/rtl/ntt_pkg.sv
// ----------------------------------------------------------------------------
// ntt_pkg
// Shared constants and helpers for the radix-2 NTT modulo 998244353.
// ----------------------------------------------------------------------------
`default_nettype none

package ntt_pkg;

  localparam int COEF_W         = 30;
  localparam int POS_W          = 6;
  localparam int DEF_LOG_LENGTH = 6;
  localparam int IN_QDEPTH      = 4;
  localparam int OUT_QDEPTH     = 4;
  localparam int APB_AW         = 3;
  localparam int APB_DW         = 32;

  localparam logic [COEF_W-1:0] PRIME      = 30'd998244353;
  localparam logic [COEF_W-1:0] ROOT_RESET = 30'd1;

  // barrett constant floor(2^60 / p)
  localparam logic [63:0] MU_WIDE    = (64'd1 << 60) / 64'd998244353;
  localparam logic [30:0] BARRETT_MU = MU_WIDE[30:0];

  localparam logic [APB_AW-1:0] ADDR_ROOT = 3'd0;

  function automatic logic [COEF_W-1:0] reduce_once(input logic [COEF_W-1:0] x);
    reduce_once = (x >= PRIME) ? x - PRIME : x;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ntt_fifo.sv
// ----------------------------------------------------------------------------
// ntt_fifo
// Small show-ahead queue with fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module ntt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic [WIDTH-1:0]         wdata,
  output logic                     full,
  input  logic                     pop,
  output logic                     empty,
  output logic [WIDTH-1:0]         rdata,
  output logic [$clog2(DEPTH):0]   count
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      fill;
  logic             wr_en;
  logic             rd_en;

  assign full  = (fill == (AW+1)'(DEPTH));
  assign empty = (fill == '0);
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;
  assign rdata = mem[rd_ptr];
  assign count = fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      if (wr_en && !rd_en) fill <= fill + 1'b1;
      else if (!wr_en && rd_en) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wdata;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ntt_front.sv
// ----------------------------------------------------------------------------
// ntt_front
// Accepts coefficients, reduces them once and queues them for the core.
// ----------------------------------------------------------------------------
`default_nettype none

module ntt_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [ntt_pkg::COEF_W-1:0]  coefficient,
  output logic                        full,
  input  logic                        q_pop,
  output logic                        q_empty,
  output logic [ntt_pkg::COEF_W-1:0]  q_data
);
  import ntt_pkg::*;

  logic [COEF_W-1:0] reduced;

  assign reduced = reduce_once(coefficient);

  ntt_fifo #(
    .WIDTH (COEF_W),
    .DEPTH (IN_QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (reduced),
    .full  (full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_data),
    .count ()
  );

endmodule

`default_nettype wire

FILE: hw/rtl/ntt_mulmod.sv
// ----------------------------------------------------------------------------
// ntt_mulmod
// Pipelined modular multiplier with barrett reduction.
// ----------------------------------------------------------------------------
`default_nettype none

module ntt_mulmod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [ntt_pkg::COEF_W-1:0]  a,
  input  logic [ntt_pkg::COEF_W-1:0]  b,
  output logic                        out_valid,
  output logic [ntt_pkg::COEF_W-1:0]  product
);
  import ntt_pkg::*;

  logic [4:0]  vld;
  logic [59:0] x1;
  logic [61:0] qm2;
  logic [31:0] x2;
  logic [31:0] x3;
  logic [31:0] qp3;
  logic [31:0] r4;
  logic [29:0] r5;
  logic [60:0] qp_full;
  logic [31:0] r_raw;

  assign qp_full = 61'(qm2[61:31]) * 61'(PRIME);
  assign r_raw   = x3 - qp3;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    x1  <= 60'(a) * 60'(b);
    qm2 <= 62'(x1[59:29]) * 62'(BARRETT_MU);
    x2  <= x1[31:0];
    qp3 <= qp_full[31:0];
    x3  <= x2;
    // estimate is short by at most two multiples of p
    r4  <= (r_raw >= 32'(PRIME)) ? r_raw - 32'(PRIME) : r_raw;
    r5  <= (r4 >= 32'(PRIME)) ? 30'(r4 - 32'(PRIME)) : r4[29:0];
  end

  assign out_valid = vld[4];
  assign product   = r5;

endmodule

`default_nettype wire

FILE: hw/rtl/ntt_core.sv
// ----------------------------------------------------------------------------
// ntt_core
// Loads coefficients bit-reversed, runs the butterfly stages in place and
// streams the transform out through a result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ntt_core #(
  parameter int LOG_LENGTH = ntt_pkg::DEF_LOG_LENGTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [ntt_pkg::COEF_W-1:0]  root,
  input  logic                        q_empty,
  input  logic [ntt_pkg::COEF_W-1:0]  q_data,
  output logic                        q_pop,
  output logic [ntt_pkg::COEF_W-1:0]  value,
  output logic [ntt_pkg::POS_W-1:0]   position,
  output logic                        last,
  output logic                        empty,
  input  logic                        pop
);
  import ntt_pkg::*;

  localparam int LENGTH = 1 << LOG_LENGTH;
  localparam int LW     = LOG_LENGTH;
  localparam int SW     = $clog2(LOG_LENGTH + 1);
  localparam int OW     = COEF_W + POS_W + 1;
  localparam int CW     = $clog2(OUT_QDEPTH) + 1;

  typedef enum logic [7:0] {
    S_LOAD     = 8'b0000_0001,
    S_SQ_ISSUE = 8'b0000_0010,
    S_SQ_WAIT  = 8'b0000_0100,
    S_BF_READ  = 8'b0000_1000,
    S_BF_MUL   = 8'b0001_0000,
    S_BF_WAIT  = 8'b0010_0000,
    S_BF_WRITE = 8'b0100_0000,
    S_EMIT     = 8'b1000_0000
  } state_t;

  state_t            state;
  logic [LW-1:0]     load_cnt;
  logic [LW-1:0]     load_rev;
  logic [SW-1:0]     sq_cnt;
  logic [SW-1:0]     stage;
  logic [LW-1:0]     j;
  logic [LW-1:0]     k;
  logic [LW-1:0]     e;
  logic [COEF_W-1:0] w;
  logic [COEF_W-1:0] u;
  logic [COEF_W-1:0] d_reg;
  logic [COEF_W-1:0] chain [LOG_LENGTH];

  logic [COEF_W-1:0] store [LENGTH];
  logic [COEF_W-1:0] rd_a;
  logic [COEF_W-1:0] rd_b;
  logic              mem_we;
  logic [LW-1:0]     mem_waddr;
  logic [COEF_W-1:0] mem_wdata;
  logic [LW-1:0]     addr_a;

  logic [LW:0]       m;
  logic              j_last;
  logic              grp_last;
  logic [LW-1:0]     idx_a;
  logic [LW-1:0]     idx_b;

  logic              mv_valid;
  logic [COEF_W-1:0] mv;
  logic              mw_valid;
  logic [COEF_W-1:0] mw;
  logic              mw_in_valid;
  logic [COEF_W-1:0] mw_a;

  logic [COEF_W:0]   s_wide;
  logic [COEF_W-1:0] sum;
  logic [COEF_W-1:0] diff;

  logic              emit_pend;
  logic [LW-1:0]     emit_pos;
  logic              emit_last;
  logic [CW-1:0]     out_count;
  logic              room;
  logic [OW-1:0]     oq_rdata;

  always_comb begin
    for (int b = 0; b < LW; b++) begin
      load_rev[LW-1-b] = load_cnt[b];
    end
  end

  assign m        = (LW+1)'(1) << stage;
  assign j_last   = ({1'b0, j} == m - 1'b1);
  assign grp_last = (({1'b0, k} + (m << 1)) == ((LW+1)'(1) << LW));
  assign idx_a    = k + j;
  assign idx_b    = LW'({1'b0, k} + {1'b0, j} + m);
  assign addr_a   = (state == S_EMIT) ? e : idx_a;

  assign s_wide = {1'b0, u} + {1'b0, mv};
  assign sum    = (s_wide >= {1'b0, PRIME}) ? COEF_W'(s_wide - {1'b0, PRIME}) : s_wide[COEF_W-1:0];
  assign diff   = (u >= mv) ? u - mv : u + PRIME - mv;

  assign q_pop = (state == S_LOAD) && !q_empty;
  assign room  = (int'(out_count) + int'(emit_pend)) < OUT_QDEPTH;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_a;
    mem_wdata = sum;
    case (state)
      S_LOAD: begin
        mem_we    = !q_empty;
        mem_waddr = load_rev;
        mem_wdata = q_data;
      end
      S_BF_WAIT: begin
        mem_we = mv_valid;
      end
      S_BF_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = idx_b;
        mem_wdata = d_reg;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) store[mem_waddr] <= mem_wdata;
    rd_a <= store[addr_a];
    rd_b <= store[idx_b];
  end

  // twiddle unit also builds the squaring chain of the root
  assign mw_in_valid = (state == S_BF_MUL) ||
                       ((state == S_SQ_ISSUE) && (sq_cnt != SW'(LOG_LENGTH - 1)));
  assign mw_a        = (state == S_BF_MUL) ? w : chain[0];

  ntt_mulmod u_mul_data (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (state == S_BF_MUL),
    .a         (w),
    .b         (rd_b),
    .out_valid (mv_valid),
    .product   (mv)
  );

  ntt_mulmod u_mul_twiddle (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mw_in_valid),
    .a         (mw_a),
    .b         (chain[0]),
    .out_valid (mw_valid),
    .product   (mw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      load_cnt  <= '0;
      sq_cnt    <= '0;
      stage     <= '0;
      j         <= '0;
      k         <= '0;
      e         <= '0;
      emit_pend <= 1'b0;
    end else begin
      emit_pend <= 1'b0;
      case (state)
        S_LOAD: begin
          if (!q_empty) begin
            load_cnt <= load_cnt + 1'b1;
            if (load_cnt == LW'(LENGTH - 1)) begin
              sq_cnt <= '0;
              state  <= S_SQ_ISSUE;
            end
          end
        end
        S_SQ_ISSUE: begin
          if (sq_cnt == SW'(LOG_LENGTH - 1)) begin
            stage <= '0;
            j     <= '0;
            k     <= '0;
            state <= S_BF_READ;
          end else begin
            state <= S_SQ_WAIT;
          end
        end
        S_SQ_WAIT: begin
          if (mw_valid) begin
            sq_cnt <= sq_cnt + 1'b1;
            state  <= S_SQ_ISSUE;
          end
        end
        S_BF_READ: begin
          state <= S_BF_MUL;
        end
        S_BF_MUL: begin
          state <= S_BF_WAIT;
        end
        S_BF_WAIT: begin
          if (mv_valid) state <= S_BF_WRITE;
        end
        S_BF_WRITE: begin
          state <= S_BF_READ;
          if (j_last) begin
            j <= '0;
            if (grp_last) begin
              k <= '0;
              if (stage == SW'(LOG_LENGTH - 1)) begin
                e     <= '0;
                state <= S_EMIT;
              end else begin
                stage <= stage + 1'b1;
              end
            end else begin
              k <= LW'({1'b0, k} + (m << 1));
            end
          end else begin
            j <= j + 1'b1;
          end
        end
        S_EMIT: begin
          if (room) begin
            emit_pend <= 1'b1;
            e         <= e + 1'b1;
            if (e == LW'(LENGTH - 1)) state <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_LOAD && !q_empty && load_cnt == LW'(LENGTH - 1)) begin
      chain[0] <= reduce_once(root);
    end
    if (state == S_SQ_WAIT && mw_valid) begin
      for (int t = LOG_LENGTH - 1; t > 0; t--) chain[t] <= chain[t-1];
      chain[0] <= mw;
    end
    if (state == S_BF_WRITE && j_last && grp_last) begin
      for (int t = 0; t < LOG_LENGTH - 1; t++) chain[t] <= chain[t+1];
    end
    if (state == S_SQ_ISSUE) w <= 30'd1;
    if (state == S_BF_MUL) u <= rd_a;
    if (state == S_BF_WAIT && mv_valid) begin
      d_reg <= diff;
      w     <= j_last ? 30'd1 : mw;
    end
    if (state == S_EMIT && room) begin
      emit_pos  <= e;
      emit_last <= (e == LW'(LENGTH - 1));
    end
  end

  ntt_fifo #(
    .WIDTH (OW),
    .DEPTH (OUT_QDEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (emit_pend),
    .wdata ({rd_a, POS_W'(emit_pos), emit_last}),
    .full  (),
    .pop   (pop),
    .empty (empty),
    .rdata (oq_rdata),
    .count (out_count)
  );

  assign value    = oq_rdata[OW-1 -: COEF_W];
  assign position = oq_rdata[POS_W:1];
  assign last     = oq_rdata[0];

endmodule

`default_nettype wire

FILE: hw/rtl/ntt_radix2_mod_prime.sv
// ----------------------------------------------------------------------------
// ntt_radix2_mod_prime
// Radix-2 number-theoretic transform modulo 998244353 with APB root register.
// ----------------------------------------------------------------------------
// Collects 2^LOG_LENGTH coefficients (one per push, one each cycle while
// full is low), runs the decimation-in-time butterflies in place on one
// memory and pops the results in natural order with last on the final one.
// Each butterfly waits on the pipelined modular multiplier, so butterflies
// do not overlap; a new block is loaded only after the previous transform
// has been emitted. Write the inverse root for the inverse
// transform (no 1/LENGTH scaling).
`default_nettype none

module ntt_radix2_mod_prime #(
  parameter int LOG_LENGTH = ntt_pkg::DEF_LOG_LENGTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ntt_pkg::APB_AW-1:0]  paddr,
  input  logic [ntt_pkg::APB_DW-1:0]  pwdata,
  output logic [ntt_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  input  logic                        push,
  output logic                        full,
  input  logic [ntt_pkg::COEF_W-1:0]  coefficient,
  output logic                        empty,
  input  logic                        pop,
  output logic [ntt_pkg::COEF_W-1:0]  value,
  output logic [ntt_pkg::POS_W-1:0]   position,
  output logic                        last
);
  import ntt_pkg::*;

  localparam int LENGTH = 1 << LOG_LENGTH;

  logic [COEF_W-1:0] root;
  logic              q_pop;
  logic              q_empty;
  logic [COEF_W-1:0] q_data;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ROOT) ? APB_DW'(root) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      root <= ROOT_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_ROOT) begin
      root <= pwdata[COEF_W-1:0];
    end
  end

  ntt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .coefficient (coefficient),
    .full        (full),
    .q_pop       (q_pop),
    .q_empty     (q_empty),
    .q_data      (q_data)
  );

  ntt_core #(
    .LOG_LENGTH (LOG_LENGTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .root     (root),
    .q_empty  (q_empty),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .value    (value),
    .position (position),
    .last     (last),
    .empty    (empty),
    .pop      (pop)
  );

`ifndef SYNTH
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> (position == POS_W'(LENGTH - 1)))
    else $error("last flagged away from final position");

  a_pos_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && position == POS_W'(LENGTH - 1)) |-> last)
    else $error("final position without last");

  a_canonical: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (value < PRIME))
    else $error("result not a canonical residue");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_ntt_radix2_mod_prime.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ntt_radix2_mod_prime
// Self-checking bench for the 64-point radix-2 NTT modulo 998244353: a
// directed table then random blocks, checked against a behavioral transform.
// ----------------------------------------------------------------------------

module tb_ntt_radix2_mod_prime;
  import ntt_pkg::*;

  localparam int NPTS = 1 << DEF_LOG_LENGTH;
  localparam logic [31:0] P32 = 32'd998244353;
  localparam logic [29:0] ROOT_FWD = 30'd922799308;  // 3^((p-1)/64)

  typedef struct packed {
    logic [COEF_W-1:0] value;
    logic [POS_W-1:0]  position;
    logic              last;
  } ntt_out_t;

  typedef struct {
    logic [COEF_W-1:0] coef;
    bit                chk;    // typed-in expectation present
    logic [COEF_W-1:0] val0;   // expected value at position 0
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  logic [COEF_W-1:0] coefficient = '0;
  logic empty;
  logic pop = 1'b0;
  logic [COEF_W-1:0] value;
  logic [POS_W-1:0] position;
  logic last;

  ntt_radix2_mod_prime u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full), .coefficient(coefficient), .empty(empty),
    .pop(pop), .value(value), .position(position), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [COEF_W-1:0] root_reg;
  logic [COEF_W-1:0] coef_mem [NPTS];
  int unsigned       load_idx;
  ntt_out_t          spectrum_q[$];
  int                n_errors = 0;
  int                send_idle = 0, recv_idle = 0;

  function automatic logic [29:0] fold(logic [29:0] x);
    return (x >= P32[29:0]) ? x - P32[29:0] : x;
  endfunction

  function automatic logic [29:0] mulp(logic [29:0] a, logic [29:0] b);
    logic [63:0] t;
    t = 64'(a) * 64'(b);
    return 30'(t % 64'(P32));
  endfunction

  function automatic logic [29:0] powp(logic [29:0] b, int unsigned e);
    logic [29:0] r;
    r = 30'd1;
    while (e != 0) begin
      if (e & 1) r = mulp(r, b);
      b = mulp(b, b);
      e = e >> 1;
    end
    return r;
  endfunction

  // accept one coefficient; on a full block, queue the 64 transformed values
  task automatic predict_coef(input logic [29:0] c);
    logic [29:0] work [NPTS];
    logic [29:0] w, wstep, u, v, wr;
    logic [30:0] s;
    int br;
    ntt_out_t o;
    coef_mem[load_idx] = fold(c);
    if (load_idx != NPTS - 1) begin
      load_idx++;
      return;
    end
    load_idx = 0;
    wr = fold(root_reg);
    for (int i = 0; i < NPTS; i++) begin
      br = 0;
      for (int b = 0; b < DEF_LOG_LENGTH; b++) br |= ((i >> b) & 1) << (DEF_LOG_LENGTH-1-b);
      work[i] = coef_mem[br];
    end
    for (int m = 1; m < NPTS; m = m * 2) begin
      wstep = powp(wr, NPTS / (2 * m));
      for (int k = 0; k < NPTS; k += 2 * m) begin
        w = 30'd1;
        for (int j = 0; j < m; j++) begin
          u = work[k+j];
          v = mulp(w, work[k+j+m]);
          s = {1'b0, u} + {1'b0, v};
          work[k+j] = (s >= P32[30:0]) ? 30'(s - P32[30:0]) : s[29:0];
          work[k+j+m] = (u >= v) ? u - v : u + P32[29:0] - v;
          w = mulp(w, wstep);
        end
      end
    end
    for (int i = 0; i < NPTS; i++) begin
      o.value = work[i];
      o.position = POS_W'(i);
      o.last = (i == NPTS - 1);
      spectrum_q.push_back(o);
    end
  endtask

  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    root_reg = data[29:0];
  endtask

  task automatic send_coef(input logic [29:0] c);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    coefficient <= c;
    do @(posedge clk); while (full);
    predict_coef(c);
  endtask

  task automatic drain_wait();
    push <= 1'b0;
    while (spectrum_q.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  // receiver
  always @(posedge clk) begin
    ntt_out_t e;
    if (!rst) begin
      if (pop && !empty) begin
        if (spectrum_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected value %0d pos %0d", value, position);
        end else begin
          e = spectrum_q.pop_front();
          if (e.value !== value || e.position !== position || e.last !== last) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: exp val %0d pos %0d last %0b, got %0d %0d %0b",
                       e.value, e.position, e.last, value, position, last);
          end
        end
      end
      pop <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    end
  end

  task automatic run_block(input int mode);
    for (int i = 0; i < NPTS; i++) begin
      case (mode)
        0: send_coef(30'($urandom_range(998244352)));
        1: send_coef(30'($urandom));                 // includes non-canonical
        default: send_coef($urandom_range(3) == 0 ? 30'h3FFF_FFFF : 30'($urandom_range(7)));
      endcase
    end
  endtask

  stim_row_t rows [4];
  logic [29:0] root_inv;

  initial begin
    root_reg = ROOT_RESET;
    load_idx = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset root of 1: value at position 0 is the plain sum of the block
    rows[0] = '{30'd0, 1'b1, 30'd0};
    rows[1] = '{30'h3FFF_FFFF, 1'b0, 30'd0};
    rows[2] = '{30'd998244352, 1'b0, 30'd0};
    rows[3] = '{30'd998244353, 1'b0, 30'd0};
    for (int b = 0; b < 2; b++) begin
      for (int i = 0; i < NPTS; i++) begin
        if (b == 0) send_coef(rows[0].coef);
        else send_coef(rows[1 + (i % 3)].coef);
        if (b == 0 && i == NPTS - 1 && rows[0].chk && spectrum_q[0].value !== rows[0].val0) begin
          n_errors++;
          if (n_errors <= 10) $display("zero block predicted nonzero");
        end
      end
    end
    drain_wait();

    root_inv = powp(ROOT_FWD, NPTS - 1);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 50; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 50; end
        default: begin send_idle = 27; recv_idle = 27; end
      endcase
      case (ph)
        0: apb_write(ADDR_ROOT, 32'(ROOT_FWD));
        1: apb_write(ADDR_ROOT, 32'(root_inv));
        2: apb_write(ADDR_ROOT, 32'h3FFF_FFFF);  // non-canonical, non-primitive
        default: apb_write(ADDR_ROOT, 32'd0);
      endcase
      run_block(ph == 3 ? 2 : ph % 2);
      drain_wait();
    end

    if (n_errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #200ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
